// ===== rtl/core/busdec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// busdec_pkg
// Shared types, codes and the address decode for the bus address decoder.
// ----------------------------------------------------------------------------
package busdec_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_IRQ   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_LOCAL  = 3'd0,
    TGT_CART   = 3'd1,
    TGT_VRAM   = 3'd2,
    TGT_OAM    = 3'd3,
    TGT_JOYPAD = 3'd4,
    TGT_TIMER  = 3'd5,
    TGT_VIDREG = 3'd6,
    TGT_UNUSED = 3'd7
  } target_t;

  localparam logic [15:0] ADDR_VRAM    = 16'h8000;
  localparam logic [15:0] ADDR_EXTRAM  = 16'hA000;
  localparam logic [15:0] ADDR_WRAM    = 16'hC000;
  localparam logic [15:0] ADDR_ECHO    = 16'hE000;
  localparam logic [15:0] ADDR_OAM     = 16'hFE00;
  localparam logic [15:0] ADDR_UNUSED  = 16'hFEA0;
  localparam logic [15:0] ADDR_IO      = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM    = 16'hFF80;
  localparam logic [15:0] ADDR_JOYPAD  = 16'hFF00;
  localparam logic [15:0] ADDR_TIMER_L = 16'hFF04;
  localparam logic [15:0] ADDR_TIMER_H = 16'hFF07;
  localparam logic [15:0] ADDR_VID_L   = 16'hFF40;
  localparam logic [15:0] ADDR_VID_H   = 16'hFF4B;
  localparam logic [15:0] ADDR_DMA     = 16'hFF46;
  localparam logic [15:0] ADDR_IF      = 16'hFF0F;

  localparam int WRAM_AW = 13;
  localparam int PAGE_AW = 8;

  // Region of an address. The DMA register lies inside the video register
  // window, so reads and writes decode the same way.
  function automatic target_t decode_target(input logic [15:0] a);
    target_t t;
    if (a < ADDR_VRAM) begin
      t = TGT_CART;
    end else if (a < ADDR_EXTRAM) begin
      t = TGT_VRAM;
    end else if (a < ADDR_WRAM) begin
      t = TGT_CART;
    end else if (a < ADDR_OAM) begin
      t = TGT_LOCAL;
    end else if (a < ADDR_UNUSED) begin
      t = TGT_OAM;
    end else if (a < ADDR_IO) begin
      t = TGT_UNUSED;
    end else if (a == ADDR_JOYPAD) begin
      t = TGT_JOYPAD;
    end else if (a >= ADDR_TIMER_L && a <= ADDR_TIMER_H) begin
      t = TGT_TIMER;
    end else if (a >= ADDR_VID_L && a <= ADDR_VID_H) begin
      t = TGT_VIDREG;
    end else begin
      t = TGT_LOCAL;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bus_address_decoder_with_local_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result of a request is offered on the out_ port from the output register
// once the local memories have been read and the output register is free. A new
// request is taken only once the current one has moved to the output register.
// Reset (synchronous, rst_n low) clears the control state and marks all high
// page bytes as zero; work RAM holds no reset value.
// ----------------------------------------------------------------------------
// bus_address_decoder_with_local_ram
// Decodes one bus request per item, answers work RAM, the I/O byte store, high
// RAM and the interrupt-enable byte locally, and describes forwarded accesses.
// ----------------------------------------------------------------------------
module bus_address_decoder_with_local_ram
  import busdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[1:0], address[17:2], write_data[25:18], interrupt_mask[33:26], zeros
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // target[2:0], device_address[18:3], device_write[19], device_data[27:20],
  // read_data[35:28], read_valid[36], dma_start[37], dma_source[53:38], zeros
  output logic [55:0]      out_tdata
);

  // The high page 0xFF00-0xFFFF lives in one 256-byte memory indexed by the
  // low address byte: I/O bytes below 0x80, high RAM from 0x80 and the
  // interrupt-enable byte in the last entry. Each entry has a valid bit so
  // that an entry never written since reset reads as zero.
  localparam int PAGE_DEPTH = 1 << PAGE_AW;
  localparam int WRAM_DEPTH = 1 << WRAM_AW;

  logic [7:0] wram [WRAM_DEPTH];
  logic [7:0] page [PAGE_DEPTH];
  logic [PAGE_DEPTH-1:0] page_vld_r;

  logic [7:0] wram_q;
  logic [7:0] page_q;

  // Request held while its memory read is under way.
  logic        busy_r;
  cmd_t        cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  wd_r;
  logic [7:0]  mask_r;

  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic [55:0] out_data_nxt;

  cmd_t        in_cmd;
  logic [15:0] in_addr;
  logic [PAGE_AW-1:0] in_page_idx;
  logic        in_fire;
  logic        advance;

  logic [PAGE_AW-1:0] page_idx;
  logic [7:0]  page_byte;
  logic        page_we;
  logic [7:0]  page_wd;
  logic        wram_we;
  target_t     tgt;
  logic        is_wram;

  logic [2:0]  o_target;
  logic [15:0] o_dev_addr;
  logic        o_dev_write;
  logic [7:0]  o_dev_data;
  logic [7:0]  o_read_data;
  logic        o_read_valid;
  logic        o_dma_start;
  logic [15:0] o_dma_source;

  assign in_cmd  = cmd_t'(in_tdata[1:0]);
  assign in_addr = in_tdata[17:2];

  // An interrupt request reads the flag byte for its read-modify-write.
  assign in_page_idx = (in_cmd == CMD_IRQ) ? ADDR_IF[PAGE_AW-1:0] : in_addr[PAGE_AW-1:0];

  // One request at a time: the next one is taken once the current one has
  // written back and moved into the output register, so a read never meets
  // a pending write to the same entry.
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = busy_r && (!out_valid_r || out_tready);

  assign page_idx  = (cmd_r == CMD_IRQ) ? ADDR_IF[PAGE_AW-1:0] : addr_r[PAGE_AW-1:0];
  assign page_byte = page_vld_r[page_idx] ? page_q : 8'h00;
  assign tgt       = decode_target(addr_r);
  assign is_wram   = addr_r < ADDR_OAM;

  // Write-back and result of the held request.
  always_comb begin
    page_we      = 1'b0;
    page_wd      = wd_r;
    wram_we      = 1'b0;
    o_target     = TGT_LOCAL;
    o_dev_addr   = 16'h0000;
    o_dev_write  = 1'b0;
    o_dev_data   = 8'h00;
    o_read_data  = 8'h00;
    o_read_valid = 1'b0;
    o_dma_start  = 1'b0;
    o_dma_source = 16'h0000;
    case (cmd_r)
      CMD_IRQ: begin
        page_we = 1'b1;
        page_wd = page_byte | mask_r;
      end
      CMD_READ, CMD_WRITE: begin
        o_target = tgt;
        if (tgt == TGT_LOCAL) begin
          if (cmd_r == CMD_WRITE) begin
            wram_we = is_wram;
            page_we = !is_wram;
          end else begin
            o_read_data  = is_wram ? wram_q : page_byte;
            o_read_valid = 1'b1;
          end
        end else if (tgt == TGT_UNUSED) begin
          if (cmd_r == CMD_READ) begin
            o_read_data  = 8'hFF;
            o_read_valid = 1'b1;
          end
        end else begin
          o_dev_addr = addr_r;
          if (cmd_r == CMD_WRITE) begin
            o_dev_write = 1'b1;
            o_dev_data  = wd_r;
            if (addr_r == ADDR_DMA) begin
              o_dma_start  = 1'b1;
              o_dma_source = {wd_r, 8'h00};
            end
          end
        end
      end
      default: begin
        // No access for the unassigned command; every field stays zero.
      end
    endcase
    out_data_nxt = {2'b00, o_dma_source, o_dma_start, o_read_valid, o_read_data,
                    o_dev_data, o_dev_write, o_dev_addr, o_target};
  end

  // Work RAM: read on acceptance, written when the request completes.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      wram_q <= wram[in_addr[WRAM_AW-1:0]];
    end
    if (advance && wram_we) begin
      wram[addr_r[WRAM_AW-1:0]] <= wd_r;
    end
  end

  // High page memory.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_q <= page[in_page_idx];
    end
    if (advance && page_we) begin
      page[page_idx] <= page_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_vld_r <= '0;
    end else if (advance && page_we) begin
      page_vld_r[page_idx] <= 1'b1;
    end
  end

  // Held request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (advance) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_cmd;
      addr_r <= in_addr;
      wd_r   <= in_tdata[25:18];
      mask_r <= in_tdata[33:26];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
